// ===== hw/rtl/top_k_and_recent_sample_tracker_top_defines.svh =====
// assertion macros for the top-k and recent sample tracker
// used by top_k_and_recent_sample_tracker_top; needs a clk and rst in scope
`ifndef TOP_K_AND_RECENT_SAMPLE_TRACKER_TOP_DEFINES_SVH
`define TOP_K_AND_RECENT_SAMPLE_TRACKER_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define TKRS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define TKRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tkrs_pkg.sv =====
// shared types and constants for the top-k and recent sample tracker
// no dependencies
package tkrs_pkg;

  localparam int KEEP_COUNT  = 32;
  localparam int SAMPLE_BITS = 12;
  localparam int POS_BITS    = 5;
  localparam int BYTE_BITS   = 8;
  localparam int NIB_BITS    = 4;
  localparam int IDX_W       = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int CNT_W       = $clog2(KEEP_COUNT + 1);

  localparam logic OP_PUSH     = 1'b0;
  localparam logic OP_DUMP     = 1'b1;
  localparam logic LIST_SORTED = 1'b0;
  localparam logic LIST_WINDOW = 1'b1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                 opcode;
    logic [BYTE_BITS-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                list_select;
    logic [POS_BITS-1:0] position;
    sample_t             sample_value;
    logic                entry_valid;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic    valid;
    sample_t value;
  } samp_t;

  typedef struct packed {
    logic    ins;
    logic    full;
    sample_t sample;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_WIN,
    S_EMPTY
  } state_t;

endpackage

// ===== hw/rtl/top_k_and_recent_sample_tracker_top.sv =====
// Top-k and recent sample tracker.
// Input channel (in_valid, in_stall, in_data): opcode push carries one stream byte;
// every second and third byte of a group of three completes a 12-bit sample.
// Each sample enters a sorted chain of KEEP_COUNT compare cells (keeps the largest,
// ascending) and a shift chain of the last KEEP_COUNT samples.
// Opcode dump reads the sorted chain from smallest up, then the window oldest
// first, last_of_run on the final result; both empty gives one marker with
// entry_valid low.
// Output channel (out_valid, out_stall, out_data) comes from one output register.
// Throughput: one push per cycle while no dump is in progress, no result. A dump
// holds in_stall high until its last result is loaded, one result per cycle
// through the read mux over the cells while the output register has room; the
// dump transfer moves the sequencer out of idle, and its first load raises
// out_valid. out_stall freezes the output register and the dump sequencer;
// pushes are taken again once the last result is loaded. Synchronous reset
// empties both chains, clears the byte phase and drops any pending result.
`include "top_k_and_recent_sample_tracker_top_defines.svh"
module top_k_and_recent_sample_tracker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tkrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tkrs_pkg::out_item_t out_data
);
  import tkrs_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_next;
  logic [CNT_W-1:0]   idx_ext;
  logic [CNT_W-1:0]   sorted_count;
  logic [CNT_W-1:0]   win_count;
  logic [CNT_W-1:0]   win_rd;
  logic               push;
  logic               room;
  logic               load;
  logic               sort_last;
  logic               win_last;
  logic               sort_ok;
  out_item_t          item_next;
  samp_t              samp;
  cell_ctl_t          ctl;
  sample_t            sort_val [KEEP_COUNT];
  sample_t            win_val  [KEEP_COUNT];
  logic [KEEP_COUNT-1:0] occ;
  logic [KEEP_COUNT-1:0] gt;
  logic [KEEP_COUNT-1:0] lt;

  assign in_stall = (state != S_IDLE);
  assign push     = in_valid && !in_stall && (in_data.opcode == OP_PUSH);

  tkrs_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (in_data.data_byte),
    .samp      (samp)
  );

  assign ctl.ins    = samp.valid;
  assign ctl.full   = (sorted_count == CNT_W'(KEEP_COUNT));
  assign ctl.sample = samp.value;

  genvar gi;
  generate
    for (gi = 0; gi < KEEP_COUNT; gi++) begin : g_cell
      sample_t left_val;
      sample_t right_val;
      sample_t win_left;
      logic    left_gt;
      logic    right_lt;

      assign occ[gi] = CNT_W'(gi) < sorted_count;

      if (gi == 0) begin : g_head
        assign left_val = '0;
        assign left_gt  = 1'b0;
        assign win_left = samp.value;
      end else begin : g_body
        assign left_val = sort_val[gi-1];
        assign left_gt  = gt[gi-1];
        assign win_left = win_val[gi-1];
      end

      if (gi == KEEP_COUNT - 1) begin : g_tail
        assign right_val = '0;
        assign right_lt  = 1'b0;
      end else begin : g_mid
        assign right_val = sort_val[gi+1];
        assign right_lt  = lt[gi+1];
      end

      tkrs_sort_cell u_sort (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ[gi]),
        .left_val  (left_val),
        .left_gt   (left_gt),
        .right_val (right_val),
        .right_lt  (right_lt),
        .value     (sort_val[gi]),
        .gt        (gt[gi]),
        .lt        (lt[gi])
      );

      tkrs_win_cell u_win (
        .clk      (clk),
        .shift    (samp.valid),
        .left_val (win_left),
        .value    (win_val[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_count <= '0;
      win_count    <= '0;
    end else if (samp.valid) begin
      if (!ctl.full) begin
        sorted_count <= sorted_count + CNT_W'(1);
      end
      if (win_count != CNT_W'(KEEP_COUNT)) begin
        win_count <= win_count + CNT_W'(1);
      end
    end
  end

  // dump sequencer
  assign room      = !out_valid || !out_stall;
  assign idx_ext   = CNT_W'(idx);
  assign sort_last = (idx_ext + CNT_W'(1)) == sorted_count;
  assign win_last  = (idx_ext + CNT_W'(1)) == win_count;
  // window cell 0 is newest, so oldest sits at win_count - 1
  assign win_rd    = win_count - CNT_W'(1) - idx_ext;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    item_next  = out_data;
    case (state)
      S_IDLE: begin
        if (in_valid && (in_data.opcode == OP_DUMP)) begin
          idx_next = '0;
          if (sorted_count != '0) begin
            state_next = S_SORT;
          end else if (win_count != '0) begin
            state_next = S_WIN;
          end else begin
            state_next = S_EMPTY;
          end
        end
      end
      S_SORT: begin
        if (room) begin
          load      = 1'b1;
          item_next = '{list_select:  LIST_SORTED,
                        position:     POS_BITS'(idx),
                        sample_value: sort_val[idx],
                        entry_valid:  1'b1,
                        last_of_run:  sort_last && (win_count == '0)};
          if (sort_last) begin
            idx_next   = '0;
            state_next = (win_count != '0) ? S_WIN : S_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      S_WIN: begin
        if (room) begin
          load      = 1'b1;
          item_next = '{list_select:  LIST_WINDOW,
                        position:     POS_BITS'(idx),
                        sample_value: win_val[win_rd[IDX_W-1:0]],
                        entry_valid:  1'b1,
                        last_of_run:  win_last};
          if (win_last) begin
            idx_next   = '0;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      S_EMPTY: begin
        if (room) begin
          load       = 1'b1;
          item_next  = '{list_select:  LIST_SORTED,
                         position:     '0,
                         sample_value: '0,
                         entry_valid:  1'b0,
                         last_of_run:  1'b1};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= item_next;
    end
  end

  // occupied part of the sorted chain stays ascending
  always_comb begin
    sort_ok = 1'b1;
    for (int i = 1; i < KEEP_COUNT; i++) begin
      if (occ[i] && (sort_val[i-1] > sort_val[i])) begin
        sort_ok = 1'b0;
      end
    end
  end

  `TKRS_ASSERT_ALWAYS(a_sorted_order, sort_ok, "sorted chain out of order")
  `TKRS_ASSERT_NEXT(a_frozen_in_dump, state != S_IDLE,
    $stable(sorted_count) && $stable(win_count), "store changed during dump")
  `TKRS_ASSERT_ALWAYS(a_marker_is_last, !out_valid || out_data.entry_valid ||
    out_data.last_of_run, "empty marker without last_of_run")
  `TKRS_ASSERT_ALWAYS(a_count_bound, (sorted_count <= CNT_W'(KEEP_COUNT)) &&
    (win_count <= CNT_W'(KEEP_COUNT)), "store count beyond capacity")

endmodule

// ===== hw/rtl/tkrs_unpack.sv =====
// byte unpacker: two 12-bit samples from every three stream bytes
// depends on tkrs_pkg
module tkrs_unpack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [tkrs_pkg::BYTE_BITS-1:0] data_byte,
  output tkrs_pkg::samp_t               samp
);
  import tkrs_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  logic [BYTE_BITS-1:0] first_byte;
  logic [BYTE_BITS-1:0] second_byte;

  always_comb begin
    phase_next = phase;
    samp.valid = 1'b0;
    samp.value = '0;
    case (phase)
      PH_FIRST: begin
        phase_next = PH_SECOND;
      end
      PH_SECOND: begin
        phase_next = PH_THIRD;
        samp.valid = push;
        samp.value = {first_byte, data_byte[BYTE_BITS-1 -: NIB_BITS]};
      end
      PH_THIRD: begin
        phase_next = PH_FIRST;
        samp.valid = push;
        samp.value = {second_byte[NIB_BITS-1:0], data_byte};
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      first_byte  <= '0;
      second_byte <= '0;
    end else if (push) begin
      phase <= phase_next;
      if (phase == PH_FIRST) begin
        first_byte <= data_byte;
      end
      if (phase == PH_SECOND) begin
        second_byte <= data_byte;
      end
    end
  end

endmodule

// ===== hw/rtl/tkrs_sort_cell.sv =====
// one cell of the ascending sorted chain; inserts in parallel with its neighbors
// depends on tkrs_pkg
module tkrs_sort_cell (
  input  logic                clk,
  input  tkrs_pkg::cell_ctl_t ctl,
  input  logic                occ,
  input  tkrs_pkg::sample_t   left_val,
  input  logic                left_gt,
  input  tkrs_pkg::sample_t   right_val,
  input  logic                right_lt,
  output tkrs_pkg::sample_t   value,
  output logic                gt,
  output logic                lt
);
  import tkrs_pkg::*;

  sample_t value_next;

  assign gt = occ && (value > ctl.sample);
  assign lt = occ && (value < ctl.sample);

  always_comb begin
    if (ctl.full) begin
      // full chain drops the minimum when the new sample is larger: everything below the new sample moves down
      if (right_lt) begin
        value_next = right_val;
      end else if (lt) begin
        value_next = ctl.sample;
      end else begin
        value_next = value;
      end
    end else begin
      // empty slots and larger entries make room by moving up
      if (!occ || gt) begin
        value_next = left_gt ? left_val : ctl.sample;
      end else begin
        value_next = value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      value <= value_next;
    end
  end

endmodule

// ===== hw/rtl/tkrs_win_cell.sv =====
// one cell of the recent-sample shift chain, newest at the head
// depends on tkrs_pkg
module tkrs_win_cell (
  input  logic              clk,
  input  logic              shift,
  input  tkrs_pkg::sample_t left_val,
  output tkrs_pkg::sample_t value
);
  import tkrs_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= left_val;
    end
  end

endmodule

// ===== dv/top_k_and_recent_sample_tracker_top_tb.sv =====
// testbench for top_k_and_recent_sample_tracker_top: byte pushes and dumps with random gaps
// and back-pressure, results checked against an in-bench model of both sample stores
// depends on tkrs_pkg and the tracker rtl only
module top_k_and_recent_sample_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 20;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // tracker model state
  phase_t    byte_phase;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  sample_t   top_vals[$];     // ascending, largest KEEP_COUNT samples
  sample_t   recent_vals[$];  // oldest first, last KEEP_COUNT samples
  out_item_t dump_entries_due[$];

  int  pushes_sent;
  int  dumps_sent;
  int  entries_checked;
  int  mismatch_count;
  bit  rx_idle_on;
  bit  tx_idle_on;
  bit  long_hold_req;

  top_k_and_recent_sample_tracker_top u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void store_sample(sample_t v);
    int idx;
    recent_vals.push_back(v);
    if (recent_vals.size() > KEEP_COUNT) void'(recent_vals.pop_front());
    if (top_vals.size() == KEEP_COUNT) begin
      // full: a sample no larger than the minimum changes nothing
      if (v <= top_vals[0]) return;
      void'(top_vals.pop_front());
    end
    idx = 0;
    while (idx < top_vals.size() && top_vals[idx] <= v) idx++;
    top_vals.insert(idx, v);
  endfunction

  function automatic void predict_tracker(in_item_t item);
    out_item_t e;
    int        total;
    int        k;
    if (item.opcode == OP_PUSH) begin
      pushes_sent++;
      case (byte_phase)
        PH_FIRST: begin
          first_byte = item.data_byte;
          byte_phase = PH_SECOND;
        end
        PH_SECOND: begin
          second_byte = item.data_byte;
          store_sample({first_byte, item.data_byte[7:4]});
          byte_phase = PH_THIRD;
        end
        default: begin
          store_sample({second_byte[3:0], item.data_byte});
          byte_phase = PH_FIRST;
        end
      endcase
    end else begin
      dumps_sent++;
      total = top_vals.size() + recent_vals.size();
      if (total == 0) begin
        e.list_select  = LIST_SORTED;
        e.position     = '0;
        e.sample_value = '0;
        e.entry_valid  = 1'b0;
        e.last_of_run  = 1'b1;
        dump_entries_due.push_back(e);
      end else begin
        k = 0;
        for (int i = 0; i < top_vals.size(); i++) begin
          k++;
          e.list_select  = LIST_SORTED;
          e.position     = POS_BITS'(i);
          e.sample_value = top_vals[i];
          e.entry_valid  = 1'b1;
          e.last_of_run  = (k == total);
          dump_entries_due.push_back(e);
        end
        for (int i = 0; i < recent_vals.size(); i++) begin
          k++;
          e.list_select  = LIST_WINDOW;
          e.position     = POS_BITS'(i);
          e.sample_value = recent_vals[i];
          e.entry_valid  = 1'b1;
          e.last_of_run  = (k == total);
          dump_entries_due.push_back(e);
        end
      end
    end
  endfunction

  function automatic void check_entry(out_item_t got);
    out_item_t want;
    if (dump_entries_due.size() == 0) begin
      $error("result with none expected: list_select %0d position %0d value %0d",
             got.list_select, got.position, got.sample_value);
      mismatch_count++;
      return;
    end
    want = dump_entries_due.pop_front();
    entries_checked++;
    if (got.list_select !== want.list_select) begin
      $error("list_select: expected %0d, got %0d", want.list_select, got.list_select);
      mismatch_count++;
    end
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      mismatch_count++;
    end
    if (got.sample_value !== want.sample_value) begin
      $error("sample_value: expected %0d, got %0d", want.sample_value, got.sample_value);
      mismatch_count++;
    end
    if (got.entry_valid !== want.entry_valid) begin
      $error("entry_valid: expected %0d, got %0d", want.entry_valid, got.entry_valid);
      mismatch_count++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
      mismatch_count++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!tx_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 15) return 8'hFF;
    // narrow band gives repeated and near-equal samples
    if (r < 45) return 8'($urandom_range(8'h7C, 8'h84));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t make_item(logic op, logic [7:0] b);
    in_item_t it;
    it.opcode    = op;
    it.data_byte = b;
    return it;
  endfunction

  // one transfer on the input side, valid held until accepted
  task automatic send_item(in_item_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tracker(item);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_push(logic [7:0] b);
    send_item(make_item(OP_PUSH, b));
  endtask

  task automatic send_dump();
    send_item(make_item(OP_DUMP, 8'($urandom_range(0, 255))));
  endtask

  // two samples in three bytes, phase must be at the first byte
  task automatic send_sample_pair(sample_t a, sample_t b);
    send_push(a[11:4]);
    send_push({a[3:0], b[11:8]});
    send_push(b[7:0]);
  endtask

  task automatic align_phase();
    while (byte_phase != PH_FIRST) send_push(pick_byte());
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (dump_entries_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_dump();
    send_item(make_item(OP_DUMP, 8'h00));
    send_item(make_item(OP_DUMP, 8'hFF));
  endtask

  task automatic test_directed_samples();
    send_push(8'h00);
    send_push(8'h00);
    send_push(8'h00);
    send_push(8'hFF);
    send_push(8'hFF);
    send_push(8'hFF);
    send_push(8'hAB);
    send_push(8'hCD);
    send_push(8'hEF);
    send_item(make_item(OP_DUMP, 8'hA5));
    // dumps in the middle of a byte group keep the held bytes
    send_push(8'h5A);
    send_item(make_item(OP_DUMP, 8'h5A));
    send_push(8'h3C);
    send_dump();
    send_push(8'h96);
    send_dump();
  endtask

  task automatic test_equal_samples();
    send_push(8'h80);
    send_push(8'h08);
    send_push(8'h00);
    send_dump();
  endtask

  task automatic test_full_store();
    sample_t lo;
    align_phase();
    repeat (20)
      send_sample_pair(sample_t'($urandom_range(2048, 4095)),
                       sample_t'($urandom_range(2048, 4095)));
    send_dump();
    // small samples enter the window only
    repeat (4)
      send_sample_pair(sample_t'($urandom_range(0, 100)), sample_t'($urandom_range(0, 100)));
    lo = top_vals[0];
    send_sample_pair(lo, lo);
    repeat (4) send_sample_pair(12'hFFF, sample_t'($urandom_range(3000, 4095)));
    send_dump();
  endtask

  task automatic test_random_mix(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        rx_idle_on = ($urandom_range(0, 3) != 0);
        tx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 8) send_dump();
      else send_push(pick_byte());
    end
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    // receiver holds off while pushes and dumps keep coming
    long_hold_req = 1'b1;
    send_dump();
    repeat (12) send_push(pick_byte());
    send_dump();
    repeat (12) send_push(pick_byte());
    send_dump();
    pause_until_drained();
    send_push(pick_byte());
    send_dump();
    pause_until_drained();
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int r;
    stall_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_entry(out_data);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (rx_idle_on) begin
          r = $urandom_range(0, 99);
          if (r >= 92) stall_left = $urandom_range(10, 40);
          else if (r >= 70) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a transfer", quiet);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    byte_phase      = PH_FIRST;
    first_byte      = '0;
    second_byte     = '0;
    pushes_sent     = 0;
    dumps_sent      = 0;
    entries_checked = 0;
    mismatch_count  = 0;
    rx_idle_on      = 1'b1;
    tx_idle_on      = 1'b1;
    long_hold_req   = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_dump();
    test_directed_samples();
    test_equal_samples();
    test_full_store();
    test_random_mix(240);
    test_backpressure();
    test_random_mix(60);

    in_valid <= 1'b0;
    while (dump_entries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d byte pushes and %0d dumps, %0d dump entries compared",
             pushes_sent, dumps_sent, entries_checked);
    $display("including empty stores, full-store eviction and a long receiver hold-off");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
